/* hw/rtl/fcr_pkg.sv */
package fcr_pkg;

  // Storage and field sizes
  localparam int MAX_ENTRIES_DEF   = 4096;
  localparam int IDX_W             = 12;
  localparam int VAL_W             = 16;
  localparam int SIZE_W            = 32;
  localparam int CFG_W             = 13;
  localparam int CLOG2_MIN         = 9;
  localparam int CLOG2_MAX         = 16;
  // ceil(size / 2^9) needs at most this many bits
  localparam int NEED_W            = SIZE_W - CLOG2_MIN + 1;

  localparam logic [VAL_W-1:0] END_MARK = 16'hFFFF;

  // Configuration register indexes
  localparam logic CFG_TABLE_ENTRIES = 1'b0;
  localparam logic CFG_CLUSTER_LOG2  = 1'b1;

  // Register reset values
  localparam logic [12:0] TABLE_ENTRIES_RST = 13'd4096;
  localparam logic [4:0]  CLUSTER_LOG2_RST  = 5'd14;

  // Request kinds
  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_READ    = 2'd1;
  localparam logic [1:0] REQ_REBUILD = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OCCUPIED  = 2'd1;
  localparam logic [1:0] ST_ZERO_SIZE = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [IDX_W-1:0]  entry_index;
    logic [VAL_W-1:0]  entry_value;
    logic [SIZE_W-1:0] file_size;
  } in_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] read_value;
  } out_res_t;

endpackage

/* hw/rtl/fat_cluster_chain_rebuild_top.sv */
// FAT16 cluster table with chain rebuild.
// Request channel: raise start with in_req while busy is low; the request is
// taken at that clock edge. Three kinds: write an entry, read an entry, and
// rebuild a chain from a start cluster and a file size in bytes.
// Result channel: exactly one result per request, shown on out_res for a
// single cycle while out_valid is high. The receiver cannot stall, so the
// result is taken in that cycle.
// Configuration: cfg_wr_en writes table_entries (index 0) or
// cluster_size_log2 (index 1) at once; write only while idle.
// Order: a write, an unused request or a rebuild whose start lies outside
// the table answers in the cycle after acceptance and busy stays low.
// A read passes through S_READ. A rebuild checks its start in S_CHECK;
// a walk then steps past the start (up to table_entries - 1 entries)
// and ends by writing the end mark in S_FINISH or on return to the start.
// The walk steps through the table one entry a cycle, paced by the single
// read port of the table memory.
// Reset: a clearing pass writes zero to every table entry, one a cycle;
// busy is high meanwhile. Configuration takes writes.
module fat_cluster_chain_rebuild_top
  import fcr_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_req_t    in_req,
  output logic       out_valid,
  output out_res_t   out_res,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int AW = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
  localparam int NW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_CHECK, S_WALK, S_FINISH
  } state_t;

  state_t state_r;

  logic [12:0]        table_entries_r;
  logic [4:0]         cluster_log2_r;
  logic [AW-1:0]      clr_addr_r;
  logic [AW-1:0]      start_r;
  logic [AW-1:0]      tail_r;
  logic [AW-1:0]      cand_r;
  logic [SIZE_W-1:0]  size_r;
  logic [NEED_W-1:0]  rem_r;
  logic               rd_ok_r;
  logic               out_valid_r;
  out_res_t           out_res_r;

  // Table memory: one write port, one registered read port
  logic [VAL_W-1:0]   mem [MAX_ENTRIES];
  logic [VAL_W-1:0]   rdata_r;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VAL_W-1:0]   mem_wdata;
  logic [AW-1:0]      mem_raddr;

  logic [NW-1:0]      eff_n;
  logic [4:0]         eff_log2;
  logic [AW-1:0]      idx_a;
  logic               idx_ok;
  logic               start_in_tbl;
  logic [SIZE_W-1:0]  size_mask;
  logic [NEED_W-1:0]  need_m1;
  logic [AW-1:0]      start_next;
  logic [AW-1:0]      cand_next;
  logic               accept;

  // Next entry of the walk, wrapping at the table size
  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a,
                                             input logic [NW-1:0] n);
    logic [NW-1:0] s;
    s = NW'(a) + NW'(1);
    if (s >= n) return '0;
    return AW'(s);
  endfunction

  // Clamped configuration
  always_comb begin
    if (table_entries_r < 13'd2) eff_n = NW'(2);
    else if (32'(table_entries_r) > MAX_ENTRIES) eff_n = NW'(MAX_ENTRIES);
    else eff_n = NW'(table_entries_r);
    if (cluster_log2_r < 5'(CLOG2_MIN)) eff_log2 = 5'(CLOG2_MIN);
    else if (cluster_log2_r > 5'(CLOG2_MAX)) eff_log2 = 5'(CLOG2_MAX);
    else eff_log2 = cluster_log2_r;
  end

  assign accept       = start && !busy;
  assign idx_a        = AW'(in_req.entry_index);
  assign idx_ok       = 32'(in_req.entry_index) < MAX_ENTRIES;
  assign start_in_tbl = 32'(in_req.entry_index) < 32'(eff_n);
  assign start_next   = wrap_inc(start_r, eff_n);
  assign cand_next    = wrap_inc(cand_r, eff_n);

  // Cluster count minus one: ceil(size / 2^log2) - 1
  assign size_mask = (32'd1 << eff_log2) - 32'd1;
  assign need_m1   = NEED_W'(size_r >> eff_log2) + NEED_W'(|(size_r & size_mask))
                     - NEED_W'(1);

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = tail_r;
    mem_wdata = '0;
    mem_raddr = idx_a;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
      end
      S_IDLE: begin
        if (accept && in_req.req_type == REQ_WRITE && idx_ok) begin
          mem_we    = 1'b1;
          mem_waddr = idx_a;
          mem_wdata = in_req.entry_value;
        end
      end
      S_CHECK: mem_raddr = start_next;
      S_WALK: begin
        mem_raddr = cand_next;
        // link a free entry onto the tail
        if (cand_r != start_r && rdata_r == '0) begin
          mem_we    = 1'b1;
          mem_wdata = VAL_W'(cand_r);
        end
      end
      S_FINISH: begin
        mem_we    = 1'b1;
        mem_wdata = END_MARK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[mem_raddr];
  end

  // Sequencer, configuration and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      clr_addr_r      <= '0;
      out_valid_r     <= 1'b0;
      table_entries_r <= TABLE_ENTRIES_RST;
      cluster_log2_r  <= CLUSTER_LOG2_RST;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_TABLE_ENTRIES: table_entries_r <= cfg_wdata;
          CFG_CLUSTER_LOG2:  cluster_log2_r  <= cfg_wdata[4:0];
          default: ;
        endcase
      end
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(MAX_ENTRIES - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            case (in_req.req_type)
              REQ_READ: begin
                rd_ok_r <= idx_ok;
                state_r <= S_READ;
              end
              REQ_REBUILD: begin
                if (!start_in_tbl) begin
                  out_valid_r <= 1'b1;
                  out_res_r   <= '{status: ST_EXHAUSTED, read_value: '0};
                end else begin
                  start_r <= idx_a;
                  size_r  <= in_req.file_size;
                  state_r <= S_CHECK;
                end
              end
              default: begin
                out_valid_r <= 1'b1;
                out_res_r   <= '{status: ST_OK, read_value: '0};
              end
            endcase
          end
        end
        S_READ: begin
          out_valid_r <= 1'b1;
          out_res_r   <= '{status: ST_OK, read_value: rd_ok_r ? rdata_r : '0};
          state_r     <= S_IDLE;
        end
        S_CHECK: begin
          tail_r <= start_r;
          cand_r <= start_next;
          rem_r  <= need_m1;
          if (rdata_r != '0) begin
            out_valid_r <= 1'b1;
            out_res_r   <= '{status: ST_OCCUPIED, read_value: '0};
            state_r     <= S_IDLE;
          end else if (size_r == '0) begin
            out_valid_r <= 1'b1;
            out_res_r   <= '{status: ST_ZERO_SIZE, read_value: '0};
            state_r     <= S_IDLE;
          end else if (need_m1 == '0) begin
            state_r <= S_FINISH;
          end else begin
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          cand_r <= cand_next;
          if (cand_r == start_r) begin
            // came round to the start: links written so far stay
            out_valid_r <= 1'b1;
            out_res_r   <= '{status: ST_EXHAUSTED, read_value: '0};
            state_r     <= S_IDLE;
          end else if (rdata_r == '0) begin
            tail_r <= cand_r;
            rem_r  <= rem_r - NEED_W'(1);
            if (rem_r == NEED_W'(1)) state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          out_valid_r <= 1'b1;
          out_res_r   <= '{status: ST_OK, read_value: '0};
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

/* hw/rtl/fcr_checker.sv */
module fcr_checker
  import fcr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input in_req_t    in_req,
  input logic       out_valid,
  input out_res_t   out_res,
  input logic       cfg_wr_en,
  input logic       cfg_index,
  input logic [CFG_W-1:0] cfg_wdata
);

  // reset always starts the clearing pass
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low after reset");

  // a write request answers in the next cycle with ok and no data
  a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.req_type == REQ_WRITE)
      |=> (out_valid && out_res.status == ST_OK && out_res.read_value == '0 && !busy))
    else $error("write request result wrong");

  // a read request makes the block busy in the next cycle and gives no result yet
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.req_type == REQ_READ) |=> (busy && !out_valid))
    else $error("read request timing wrong");

  // only reads carry data, so a failing status has zero data
  a_status_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status != ST_OK) |-> (out_res.read_value == '0))
    else $error("data on a failed request");

  // register writes come while idle, with known index and data
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |-> (!busy && !$isunknown({cfg_index, cfg_wdata})))
    else $error("register write while busy");

endmodule

bind fat_cluster_chain_rebuild_top fcr_checker u_fcr_checker (.*);

/* verif/fcr_chain_checker.sv */
`timescale 1ns / 1ps
module fcr_chain_checker
  import fcr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  in_req_t          in_req,
  input  logic             out_valid,
  input  out_res_t         out_res,
  input  logic             cfg_wr_en,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               fail_cnt,
  output int               pending_cnt
);

  // Shadow of the cluster table and of both registers
  logic [VAL_W-1:0] fat_mirror [MAX_ENTRIES_DEF];
  logic [CFG_W-1:0] entries_reg;
  logic [4:0]       log2_reg;
  out_res_t         pending_results [$];
  out_res_t         exp_res;

  // Table size as the walk sees it
  function automatic int unsigned walk_len();
    if (entries_reg < 2) return 2;
    if (entries_reg > MAX_ENTRIES_DEF) return MAX_ENTRIES_DEF;
    return 32'(entries_reg);
  endfunction

  // Cluster shift as the walk sees it
  function automatic int unsigned cluster_shift();
    if (log2_reg < CLOG2_MIN) return CLOG2_MIN;
    if (log2_reg > CLOG2_MAX) return CLOG2_MAX;
    return 32'(log2_reg);
  endfunction

  // Walk forward from the first cluster, linking free entries onto the tail
  function automatic logic [1:0] chain_rebuild(logic [IDX_W-1:0] first,
                                               logic [SIZE_W-1:0] size);
    int unsigned     n;
    int unsigned     sh;
    longint unsigned need;
    longint unsigned linked;
    int unsigned     tail;
    int unsigned     pos;
    n = walk_len();
    if (first >= n) return ST_EXHAUSTED;
    if (fat_mirror[first] != '0) return ST_OCCUPIED;
    if (size == '0) return ST_ZERO_SIZE;
    sh     = cluster_shift();
    need   = (longint'(size) + ((64'd1 << sh) - 64'd1)) >> sh;
    linked = 1;
    tail   = 32'(first);
    pos    = 32'(first);
    while (linked < need) begin
      pos++;
      if (pos >= n) pos = 0;
      // back at the start: out of free clusters, partial links stay
      if (pos == first) return ST_EXHAUSTED;
      if (fat_mirror[pos] == '0) begin
        fat_mirror[tail] = VAL_W'(pos);
        tail = pos;
        linked++;
      end
    end
    fat_mirror[tail] = END_MARK;
    return ST_OK;
  endfunction

  // Result of one request, updating the shadow table on the way
  function automatic out_res_t table_result(in_req_t r);
    out_res_t res;
    res = '0;
    case (r.req_type)
      REQ_WRITE:   fat_mirror[r.entry_index] = r.entry_value;
      REQ_READ:    res.read_value = fat_mirror[r.entry_index];
      REQ_REBUILD: res.status = chain_rebuild(r.entry_index, r.file_size);
      default:     ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ENTRIES_DEF; i++) fat_mirror[i] = '0;
      entries_reg = TABLE_ENTRIES_RST;
      log2_reg    = CLUSTER_LOG2_RST;
      pending_results.delete();
    end else begin
      // register writes
      if (cfg_wr_en) begin
        if (cfg_index == CFG_TABLE_ENTRIES) entries_reg = cfg_wdata;
        else log2_reg = cfg_wdata[4:0];
      end
      // compare a result with the oldest outstanding request
      if (out_valid !== 1'b0) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: status %0d read_value 0x%04h",
                 out_res.status, out_res.read_value);
          fail_cnt++;
        end else begin
          exp_res = pending_results.pop_front();
          if (out_res.status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, out_res.status);
            fail_cnt++;
          end
          if (out_res.read_value !== exp_res.read_value) begin
            $error("read_value: expected 0x%04h, got 0x%04h",
                   exp_res.read_value, out_res.read_value);
            fail_cnt++;
          end
        end
      end
      // accepted request
      if (start && busy === 1'b0) pending_results.push_back(table_result(in_req));
    end
    pending_cnt = pending_results.size();
  end

endmodule

/* verif/tb_fat_cluster_chain_rebuild_top.sv */
`timescale 1ns / 1ps
module tb_fat_cluster_chain_rebuild_top;
  import fcr_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  in_req_t          in_req    = '0;
  logic             out_valid;
  out_res_t         out_res;
  logic             cfg_wr_en = 1'b0;
  logic             cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  int               fail_cnt;
  int               pending_cnt;

  // Sender's view of the effective configuration, for picking indexes and sizes
  int unsigned tb_entries = MAX_ENTRIES_DEF;
  int unsigned tb_log2    = 14;
  int unsigned idle_pct   = 35;

  always #4 clk = ~clk;

  fat_cluster_chain_rebuild_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  fcr_chain_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_res     (out_res),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt)
  );

  function automatic in_req_t make_req(logic [1:0] kind, logic [IDX_W-1:0] idx,
                                       logic [VAL_W-1:0] val, logic [SIZE_W-1:0] size);
    in_req_t r;
    r.req_type    = kind;
    r.entry_index = idx;
    r.entry_value = val;
    r.file_size   = size;
    return r;
  endfunction

  // Present a request from a falling edge and hold it until busy is low
  task automatic send_req(in_req_t r);
    logic        taken;
    int unsigned gap;
    start  <= 1'b1;
    in_req <= r;
    taken = 1'b0;
    while (!taken) begin
      taken = (busy === 1'b0);
      @(negedge clk);
    end
    if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      gap = $urandom_range(2, 1);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stop sending and let every outstanding request complete
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending_cnt != 0 || busy !== 1'b0) @(negedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [CFG_W-1:0] data);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_TABLE_ENTRIES) begin
      tb_entries = (data < 2) ? 2 : (data > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : data;
    end else begin
      tb_log2 = (data[4:0] < CLOG2_MIN) ? CLOG2_MIN :
                (data[4:0] > CLOG2_MAX) ? CLOG2_MAX : data[4:0];
    end
  endtask

  // Mostly in-table indexes and short chains, with some noise
  function automatic in_req_t random_req();
    in_req_t     r;
    int unsigned roll;
    int unsigned pick;
    int unsigned clusters;
    r.req_type    = REQ_UNUSED;
    r.entry_index = IDX_W'($urandom());
    r.entry_value = VAL_W'($urandom());
    r.file_size   = $urandom();
    if ($urandom_range(99, 0) < 85) r.entry_index = IDX_W'($urandom_range(tb_entries - 1, 0));
    roll = $urandom_range(99, 0);
    if (roll < 25) begin
      r.req_type = REQ_WRITE;
      // freeing entries keeps room for new chains
      if ($urandom_range(1, 0) == 0) r.entry_value = '0;
    end else if (roll < 50) begin
      r.req_type = REQ_READ;
    end else if (roll < 95) begin
      r.req_type = REQ_REBUILD;
      pick = $urandom_range(99, 0);
      if (pick < 8) begin
        r.file_size = '0;
      end else if (pick >= 16) begin
        clusters    = $urandom_range(6, 1);
        r.file_size = ((clusters - 1) << tb_log2) + $urandom_range(1 << tb_log2, 1);
      end
    end
    return r;
  endfunction

  task automatic run_phase(logic [CFG_W-1:0] ents, logic [4:0] shift, int count,
                           int unsigned pct);
    logic [7:0] junk;
    junk = 8'($urandom());
    write_cfg(CFG_TABLE_ENTRIES, ents);
    write_cfg(CFG_CLUSTER_LOG2, {junk, shift});
    idle_pct = pct;
    repeat (count) send_req(random_req());
  endtask

  // Overall time limit
  initial begin
    #25_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // default table: reads, writes, unused kind and start checks
    send_req(make_req(REQ_READ, 12'h000, 16'h0000, 32'h0));
    send_req(make_req(REQ_READ, 12'hFFF, 16'h0000, 32'h0));
    send_req(make_req(REQ_WRITE, 12'hFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_req(make_req(REQ_READ, 12'hFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_req(make_req(REQ_WRITE, 12'hAAA, 16'hAAAA, 32'hAAAA_AAAA));
    send_req(make_req(REQ_WRITE, 12'h555, 16'h5555, 32'h5555_5555));
    send_req(make_req(REQ_READ, 12'hAAA, 16'h0000, 32'h0));
    send_req(make_req(REQ_UNUSED, 12'hFFF, 16'hFFFF, 32'hFFFF_FFFF));
    // occupied start wins over zero size
    send_req(make_req(REQ_REBUILD, 12'hAAA, 16'h0000, 32'd100));
    send_req(make_req(REQ_REBUILD, 12'hAAA, 16'h0000, 32'd0));
    send_req(make_req(REQ_REBUILD, 12'd100, 16'hFFFF, 32'd0));
    // single cluster, then exactly one byte over a cluster
    send_req(make_req(REQ_REBUILD, 12'd200, 16'h0000, 32'd1));
    send_req(make_req(REQ_READ, 12'd200, 16'h0000, 32'h0));
    send_req(make_req(REQ_REBUILD, 12'd300, 16'h0000, 32'd16385));
    send_req(make_req(REQ_READ, 12'd300, 16'h0000, 32'h0));
    send_req(make_req(REQ_READ, 12'd301, 16'h0000, 32'h0));
    // wrap past an occupied last entry, linking cluster zero
    send_req(make_req(REQ_REBUILD, 12'd4094, 16'h0000, 32'd49152));
    send_req(make_req(REQ_READ, 12'd4094, 16'h0000, 32'h0));
    send_req(make_req(REQ_READ, 12'd0, 16'h0000, 32'h0));

    // eight entries, cluster size below range
    write_cfg(CFG_TABLE_ENTRIES, 13'd8);
    write_cfg(CFG_CLUSTER_LOG2, 13'd0);
    send_req(make_req(REQ_REBUILD, 12'd8, 16'h0000, 32'd1));
    send_req(make_req(REQ_REBUILD, 12'hFFF, 16'h0000, 32'd1));
    send_req(make_req(REQ_REBUILD, 12'd5, 16'h0000, 32'd2048));
    send_req(make_req(REQ_READ, 12'd7, 16'h0000, 32'h0));
    // walk runs out of free clusters with some linked
    send_req(make_req(REQ_REBUILD, 12'd3, 16'h0000, 32'hFFFF_FFFF));
    send_req(make_req(REQ_READ, 12'd3, 16'h0000, 32'h0));
    send_req(make_req(REQ_READ, 12'd4, 16'h0000, 32'h0));

    // table below range, cluster size above range: walk fails with nothing linked
    write_cfg(CFG_TABLE_ENTRIES, 13'd0);
    write_cfg(CFG_CLUSTER_LOG2, 13'd31);
    send_req(make_req(REQ_WRITE, 12'd1, 16'h0000, 32'h0));
    send_req(make_req(REQ_REBUILD, 12'd1, 16'h0000, 32'd65537));
    send_req(make_req(REQ_READ, 12'd1, 16'h0000, 32'h0));

    // random part over several settings, one stretch without gaps
    run_phase(13'd4096, 5'd14, 25, 35);
    run_phase(13'd8,    5'd9,  20, 35);
    run_phase(13'd64,   5'd10, 20, 0);
    run_phase(13'd8191, 5'd16, 15, 35);
    run_phase(13'd1,    5'd16, 10, 35);
    run_phase(13'd1000, 5'd12, 20, 35);

    drain();
    repeat (16) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/fcr_pkg.sv
hw/rtl/fat_cluster_chain_rebuild_top.sv
hw/rtl/fcr_checker.sv
verif/fcr_chain_checker.sv
verif/tb_fat_cluster_chain_rebuild_top.sv
